FILE: hw/rtl/dmxrx_pkg.sv
// Shared types and codes for the radio lighting packet receiver.
// No dependencies; used by dmx_radio_packet_receiver_core.
package dmxrx_pkg;

   // Request codes carried in the action field
   localparam logic [1:0] ACT_POLL = 2'd0;
   localparam logic [1:0] ACT_BYTE = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // Register indexes on the csr port
   localparam logic [0:0] CSR_WARN_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_LOST_THRESHOLD = 1'b1;

   localparam int CSR_W = 11;
   localparam logic [CSR_W-1:0] WARN_RESET = 11'd50;
   localparam logic [CSR_W-1:0] LOST_RESET = 11'd1000;
   localparam logic [10:0] LOSS_MAX = 11'h7FF;

   // LED state bits
   localparam logic [1:0] LED_RED   = 2'b01;
   localparam logic [1:0] LED_GREEN = 2'b10;
   localparam logic [1:0] LED_BOTH  = 2'b11;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       packet_start;
      logic [8:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       packet_done;
      logic       packet_good;
      logic       led_red;
      logic       led_green;
      logic       search_request;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COMMIT
   } state_type;

endpackage

FILE: hw/rtl/dmxrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write to the same address returns old data.
module dmxrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                       read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: hw/rtl/dmx_radio_packet_receiver_core.sv
// Radio lighting packet receiver: byte assembly, check, slot store, link status.
// Depends on dmxrx_pkg and dmxrx_ram.
// Every accepted item gives its result (rsp_strobe) in the cycle after it is accepted.
// Polls, reads and ordinary payload bytes are taken one per cycle while busy is low;
// a check byte that passes starts a commit that holds busy while it copies COMMIT_N
// buffered slots, one per cycle through the single store write port, and while
// the last write lands when that slot falls inside the store.
// Reset: synchronous; a clearing pass writes zero to all STORE_SLOTS entries
// with busy high. The result side cannot stall.
module dmx_radio_packet_receiver_core #(
   parameter int SLOTS_PER_PACKET = 30,
   parameter int PAYLOAD_BYTES    = 32,
   parameter int STORE_SLOTS      = 512
) (
   input  logic                clock,
   input  logic                reset,
   // item request channel
   input  logic                start,
   output logic                busy,
   input  dmxrx_pkg::req_type  req,
   // result channel
   output logic                rsp_strobe,
   output dmxrx_pkg::rsp_type  rsp,
   // register writes
   input  logic                csr_write_enable,
   input  logic [0:0]          csr_index,
   input  logic [dmxrx_pkg::CSR_W-1:0] csr_data
);

   // Slots that a payload can actually carry: slot bytes sitting on or past
   // the check byte are never used.
   localparam int COMMIT_N = (SLOTS_PER_PACKET < PAYLOAD_BYTES - 2) ?
                             SLOTS_PER_PACKET : PAYLOAD_BYTES - 2;
   localparam int LAST     = PAYLOAD_BYTES - 1;
   localparam int POS_W    = $clog2(PAYLOAD_BYTES);
   localparam int ADDR_W   = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
   localparam int BUF_AW   = (SLOTS_PER_PACKET > 1) ? $clog2(SLOTS_PER_PACKET) : 1;
   localparam int CNT_W    = (COMMIT_N > 1) ? $clog2(COMMIT_N) : 1;
   localparam int ODD_W    = $clog2(COMMIT_N + 1);
   localparam int DST_W    = $clog2(256 * SLOTS_PER_PACKET);

   // control
   dmxrx_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DST_W-1:0]     dst_ff, dst_in;
   logic                 cmt_v_ff, cmt_v_in;
   logic [DST_W-1:0]     cmt_dst_ff, cmt_dst_in;

   // packet assembly and link status
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           pkt_ff, pkt_in;
   logic [ODD_W-1:0]     odd_ff, odd_in;
   logic [10:0]          loss_ff, loss_in;
   logic [1:0]           led_ff, led_in;
   logic [dmxrx_pkg::CSR_W-1:0] warn_ff, warn_in;
   logic [dmxrx_pkg::CSR_W-1:0] lost_ff, lost_in;

   // result register; read_value comes straight from the store's read register
   logic                 rsp_strobe_ff, rsp_strobe_in;
   dmxrx_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rd_sel_ff, rd_sel_in;

   // memory ports
   logic                 st_we;
   logic [ADDR_W-1:0]    st_waddr;
   logic [7:0]           st_wdata;
   logic [ADDR_W-1:0]    st_raddr;
   logic [7:0]           st_rdata;
   logic                 buf_we;
   logic [BUF_AW-1:0]    buf_waddr;
   logic [BUF_AW-1:0]    buf_raddr;
   logic [7:0]           buf_rdata;

   logic                 accept;
   logic [POS_W-1:0]     pos;
   logic [POS_W:0]       pos_m1;

   // Store: the clearing pass and commit writes share the write port; reads
   // of the store only happen while neither is running.
   dmxrx_ram #(.WIDTH(8), .DEPTH(STORE_SLOTS)) u_store (
      .clock        (clock),
      .write_enable (st_we),
      .write_addr   (st_waddr),
      .write_data   (st_wdata),
      .read_addr    (st_raddr),
      .read_data    (st_rdata)
   );

   // Slot bytes of the payload in flight, copied to the store on a good check.
   dmxrx_ram #(.WIDTH(8), .DEPTH(SLOTS_PER_PACKET)) u_payload (
      .clock        (clock),
      .write_enable (buf_we),
      .write_addr   (buf_waddr),
      .write_data   (req.data_byte),
      .read_addr    (buf_raddr),
      .read_data    (buf_rdata)
   );

   // Busy covers the last commit write still in flight so a read right after
   // a commit never races the write to the same slot.
   assign busy   = (state_ff != dmxrx_pkg::ST_IDLE) || cmt_v_ff;
   assign accept = start && !busy;

   assign pos    = req.packet_start ? '0 : pos_ff;
   assign pos_m1 = {1'b0, pos} - {{POS_W{1'b0}}, 1'b1};

   assign st_raddr  = ADDR_W'(req.slot_index);
   assign buf_waddr = BUF_AW'(pos_m1);
   assign buf_raddr = BUF_AW'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dmxrx_pkg::ST_CLEAR;
         clr_ff        <= '0;
         cnt_ff        <= '0;
         cmt_v_ff      <= 1'b0;
         pos_ff        <= '0;
         pkt_ff        <= '0;
         odd_ff        <= '0;
         loss_ff       <= '0;
         led_ff        <= dmxrx_pkg::LED_BOTH;
         warn_ff       <= dmxrx_pkg::WARN_RESET;
         lost_ff       <= dmxrx_pkg::LOST_RESET;
         rsp_strobe_ff <= 1'b0;
         rd_sel_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cnt_ff        <= cnt_in;
         cmt_v_ff      <= cmt_v_in;
         pos_ff        <= pos_in;
         pkt_ff        <= pkt_in;
         odd_ff        <= odd_in;
         loss_ff       <= loss_in;
         led_ff        <= led_in;
         warn_ff       <= warn_in;
         lost_ff       <= lost_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_sel_ff     <= rd_sel_in;
      end
      dst_ff     <= dst_in;
      cmt_dst_ff <= cmt_dst_in;
      rsp_ff     <= rsp_in;
   end

   // register writes
   always_comb begin
      warn_in = warn_ff;
      lost_in = lost_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dmxrx_pkg::CSR_WARN_THRESHOLD: warn_in = csr_data;
            dmxrx_pkg::CSR_LOST_THRESHOLD: lost_in = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer, item decode and store write port
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      dst_in        = dst_ff;
      cmt_v_in      = 1'b0;
      cmt_dst_in    = dst_ff;
      pos_in        = pos_ff;
      pkt_in        = pkt_ff;
      odd_in        = odd_ff;
      loss_in       = loss_ff;
      led_in        = led_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rd_sel_in     = 1'b0;
      buf_we        = 1'b0;

      // commit write lands in the cycle after its buffer read
      st_we    = cmt_v_ff;
      st_waddr = ADDR_W'(cmt_dst_ff);
      st_wdata = buf_rdata;

      unique case (state_ff)
         dmxrx_pkg::ST_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = '0;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_SLOTS - 1)) begin
               state_in = dmxrx_pkg::ST_IDLE;
            end
         end
         dmxrx_pkg::ST_COMMIT: begin
            // slot writes at or beyond the store end are dropped here
            cmt_v_in = (32'(dst_ff) < STORE_SLOTS);
            cnt_in   = cnt_ff + CNT_W'(1);
            dst_in   = dst_ff + DST_W'(1);
            if (cnt_ff == CNT_W'(COMMIT_N - 1)) begin
               state_in = dmxrx_pkg::ST_IDLE;
            end
         end
         dmxrx_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               unique case (req.action)
                  dmxrx_pkg::ACT_POLL: begin
                     if (loss_ff != dmxrx_pkg::LOSS_MAX) begin
                        loss_in = loss_ff + 11'd1;
                     end
                  end
                  dmxrx_pkg::ACT_BYTE: begin
                     loss_in = '0;
                     led_in  = dmxrx_pkg::LED_GREEN;
                     if (pos == '0) begin
                        pkt_in = req.data_byte;
                        odd_in = '0;
                     end else if (32'(pos) < LAST) begin
                        if (32'(pos) <= SLOTS_PER_PACKET) begin
                           buf_we = 1'b1;
                           odd_in = odd_ff + ODD_W'(req.data_byte[0]);
                        end
                     end else begin
                        // check byte
                        rsp_in.packet_done = 1'b1;
                        if (req.data_byte == 8'(odd_ff)) begin
                           rsp_in.packet_good = 1'b1;
                           state_in = dmxrx_pkg::ST_COMMIT;
                           cnt_in   = '0;
                           dst_in   = DST_W'(pkt_ff) * DST_W'(SLOTS_PER_PACKET);
                        end
                     end
                     pos_in = (32'(pos) >= LAST) ? '0 : pos + POS_W'(1);
                  end
                  dmxrx_pkg::ACT_READ: begin
                     // out-of-range slot reads give zero
                     rd_sel_in = (32'(req.slot_index) < STORE_SLOTS);
                  end
                  default: ;
               endcase

               // link status from the updated loss count; at exactly the
               // lost threshold the LEDs hold their previous state
               if (loss_in > warn_ff && loss_in < lost_ff) begin
                  led_in = dmxrx_pkg::LED_BOTH;
               end else if (loss_in > lost_ff) begin
                  led_in = dmxrx_pkg::LED_RED;
               end
               rsp_in.led_red        = (led_in & dmxrx_pkg::LED_RED) != 2'b00;
               rsp_in.led_green      = (led_in & dmxrx_pkg::LED_GREEN) != 2'b00;
               rsp_in.search_request = loss_in > lost_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      rsp            = rsp_ff;
      rsp.read_value = rd_sel_ff ? st_rdata : 8'd0;
   end

endmodule

FILE: verif/tb_dmx_radio_packet_receiver_core.sv
// Self-checking bench for dmx_radio_packet_receiver_core: payload assembly, check byte,
// slot store commit, loss counter, LEDs and search request, over several threshold settings.
// Depends on dmxrx_pkg and the core RTL; needs no files or arguments.
module tb_dmx_radio_packet_receiver_core;

   // Block geometry, kept at the core's defaults
   localparam int SLOTS_PER_PACKET = 30;
   localparam int PAYLOAD_BYTES    = 32;
   localparam int STORE_SLOTS      = 512;

   // Action code with no defined meaning: status only, nothing changes
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Cap on the length of the run, in clock cycles
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   dmxrx_pkg::req_type            req_bus = '0;
   logic                          rsp_strobe;
   dmxrx_pkg::rsp_type            rsp;
   logic                          csr_write_enable = 1'b0;
   logic [0:0]                    csr_index = dmxrx_pkg::CSR_WARN_THRESHOLD;
   logic [dmxrx_pkg::CSR_W-1:0]   csr_data = '0;

   dmx_radio_packet_receiver_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req              (req_bus),
      .rsp_strobe       (rsp_strobe),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Scoreboard: carries its own copy of the receiver state, works out the status
   // for each accepted item and checks results in order against it.
   class receiver_scoreboard;
      logic [7:0]          lamp_levels [STORE_SLOTS];
      logic [7:0]          frame_slots [SLOTS_PER_PACKET];
      int unsigned         frame_pos;
      logic [7:0]          page;
      int unsigned         odd_slots;
      logic [10:0]         poll_misses;
      logic [1:0]          lamps;
      logic [10:0]         warn_level;
      logic [10:0]         lost_level;
      dmxrx_pkg::rsp_type  pending_outcomes [$];
      int unsigned         fail_count;

      function new();
         foreach (lamp_levels[i]) lamp_levels[i] = '0;
         foreach (frame_slots[i]) frame_slots[i] = '0;
         frame_pos   = 0;
         page        = '0;
         odd_slots   = 0;
         poll_misses = '0;
         lamps       = dmxrx_pkg::LED_BOTH;
         warn_level  = dmxrx_pkg::WARN_RESET;
         lost_level  = dmxrx_pkg::LOST_RESET;
         fail_count  = 0;
      endfunction

      function void set_thresholds(input logic [10:0] warn, input logic [10:0] lost);
         warn_level = warn;
         lost_level = lost;
      endfunction

      // One step of the receiver: returns the status the core should report
      function dmxrx_pkg::rsp_type advance_receiver(input dmxrx_pkg::req_type r);
         dmxrx_pkg::rsp_type o;
         int unsigned        base;
         int unsigned        dst;
         o = '0;
         case (r.action)
            dmxrx_pkg::ACT_POLL: begin
               if (poll_misses != dmxrx_pkg::LOSS_MAX) poll_misses++;
            end
            dmxrx_pkg::ACT_BYTE: begin
               poll_misses = '0;
               lamps       = dmxrx_pkg::LED_GREEN;
               if (r.packet_start) frame_pos = 0;
               if (frame_pos == 0) begin
                  page      = r.data_byte;
                  odd_slots = 0;
               end else if (frame_pos < PAYLOAD_BYTES - 1) begin
                  // bytes past the last slot and before the check are padding
                  if (frame_pos <= SLOTS_PER_PACKET) begin
                     frame_slots[frame_pos - 1] = r.data_byte;
                     odd_slots += r.data_byte[0];
                  end
               end else begin
                  o.packet_done = 1'b1;
                  if (int'(r.data_byte) == odd_slots) begin
                     o.packet_good = 1'b1;
                     base = int'(page) * SLOTS_PER_PACKET;
                     for (int i = 0; i < SLOTS_PER_PACKET; i++) begin
                        // slots landing on or past the check byte never existed
                        if (i + 1 >= PAYLOAD_BYTES - 1) break;
                        dst = base + i;
                        if (dst < STORE_SLOTS) lamp_levels[dst] = frame_slots[i];
                     end
                  end
               end
               if (frame_pos >= PAYLOAD_BYTES - 1) frame_pos = 0;
               else frame_pos++;
            end
            dmxrx_pkg::ACT_READ: begin
               if (r.slot_index < STORE_SLOTS) o.read_value = lamp_levels[r.slot_index];
            end
            default: ;
         endcase
         // threshold rule; loss equal to the lost level leaves the LEDs alone
         if (poll_misses > warn_level && poll_misses < lost_level) begin
            lamps = dmxrx_pkg::LED_BOTH;
         end else if (poll_misses > lost_level) begin
            lamps = dmxrx_pkg::LED_RED;
         end
         o.led_red        = |(lamps & dmxrx_pkg::LED_RED);
         o.led_green      = |(lamps & dmxrx_pkg::LED_GREEN);
         o.search_request = (poll_misses > lost_level);
         return o;
      endfunction

      function void note_item(input dmxrx_pkg::req_type r);
         pending_outcomes.push_back(advance_receiver(r));
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(input dmxrx_pkg::rsp_type got);
         dmxrx_pkg::rsp_type want;
         if (pending_outcomes.size() == 0) begin
            $error("status result with no item outstanding: %p", got);
            fail_count++;
            return;
         end
         want = pending_outcomes.pop_front();
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("packet_done", want.packet_done, got.packet_done);
         compare_field("packet_good", want.packet_good, got.packet_good);
         compare_field("led_red", want.led_red, got.led_red);
         compare_field("led_green", want.led_green, got.led_green);
         compare_field("search_request", want.search_request, got.search_request);
      endfunction
   endclass

   receiver_scoreboard sb = new();

   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;
   int unsigned cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("dmx_radio_packet_receiver_core regression: fail");
      $finish;
   end

   // Result side never stalls: every strobe is a result to check.
   // Sampling at the edge sees the values of the cycle that edge ends.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp);
   end

   function automatic dmxrx_pkg::req_type make_req(input logic [1:0] action,
                                                   input logic [7:0] data,
                                                   input logic first,
                                                   input logic [8:0] slot);
      dmxrx_pkg::req_type r;
      r.action       = action;
      r.data_byte    = data;
      r.packet_start = first;
      r.slot_index   = slot;
      return r;
   endfunction

   // Given action, everything else random (unused fields get exercised too)
   function automatic dmxrx_pkg::req_type noise_req(input logic [1:0] action);
      return make_req(action, 8'($urandom), 1'($urandom), 9'($urandom));
   endfunction

   // Holds the item until the core takes it (start high, busy low at an edge).
   // Sender runs in bursts; at the end of a burst it may drop start for a while.
   task automatic send_item(input dmxrx_pkg::req_type r);
      start   <= 1'b1;
      req_bus <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_item(r);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // Sender holds off until every status is back and the core is not committing
   task automatic pause_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_thresholds(input logic [10:0] warn, input logic [10:0] lost);
      csr_write_enable <= 1'b1;
      csr_index        <= dmxrx_pkg::CSR_WARN_THRESHOLD;
      csr_data         <= warn;
      @(posedge clock);
      csr_index        <= dmxrx_pkg::CSR_LOST_THRESHOLD;
      csr_data         <= lost;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_thresholds(warn, lost);
   endtask

   // One payload: page number, slot bytes, check byte. pass_check picks a good or
   // bad check; cut_at < PAYLOAD_BYTES truncates the payload; with_start=0 relies
   // on the position being back at zero. Stray polls/reads get mixed in now and then.
   task automatic send_packet(input logic [7:0] number, input bit pass_check,
                              input int unsigned cut_at, input bit with_start);
      int unsigned        odd;
      dmxrx_pkg::req_type r;
      odd = 0;
      for (int pos = 0; pos < PAYLOAD_BYTES && pos != cut_at; pos++) begin
         r = noise_req(dmxrx_pkg::ACT_BYTE);
         r.packet_start = (pos == 0) ? with_start : 1'b0;
         if (pos == 0) begin
            r.data_byte = number;
         end else if (pos == PAYLOAD_BYTES - 1) begin
            // a miss is odd+1..odd+201, never wraps back onto odd
            r.data_byte = pass_check ? 8'(odd) : 8'(odd + 1 + $urandom_range(0, 200));
         end else if (pos <= SLOTS_PER_PACKET) begin
            odd += r.data_byte[0];
         end
         send_item(r);
         if ($urandom_range(0, 19) == 0)
            send_item(noise_req($urandom_range(0, 1) ? dmxrx_pkg::ACT_POLL
                                                     : dmxrx_pkg::ACT_READ));
      end
   endtask

   // Mostly well-formed payloads with random content, plus poll runs, reads,
   // stray bytes and unused actions
   task automatic run_random(input int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned n;
      logic [7:0]  number;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // pages 0..16 fit the store, 17 straddles its end, others fall off it
            n = $urandom_range(0, 9);
            number = (n < 8) ? 8'($urandom_range(0, 16)) :
                     (n == 8) ? 8'd17 : 8'($urandom);
            send_packet(number, $urandom_range(0, 4) != 0,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAYLOAD_BYTES - 1)
                                                    : PAYLOAD_BYTES,
                        $urandom_range(0, 9) != 0);
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 30)) send_item(noise_req(dmxrx_pkg::ACT_POLL));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) send_item(noise_req(dmxrx_pkg::ACT_READ));
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 3)) send_item(noise_req(dmxrx_pkg::ACT_BYTE));
         end else begin
            send_item(noise_req(2'($urandom)));
         end
      end
   endtask

   initial begin
      logic [10:0] warn;
      logic [10:0] lost;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset thresholds. The core's clearing pass holds busy,
      // so the first item simply waits for it.
      send_item(make_req(dmxrx_pkg::ACT_POLL, 8'hFF, 1'b1, 9'h1FF));
      send_item(make_req(ACT_UNUSED, 8'hFF, 1'b1, 9'h1FF));
      send_item(make_req(dmxrx_pkg::ACT_READ, 8'h00, 1'b0, 9'd0));
      send_item(make_req(dmxrx_pkg::ACT_READ, 8'hFF, 1'b1, 9'd511));
      // page 17 starts at slot 510: two slots land, the rest drop off the store
      send_packet(8'd17, 1'b1, PAYLOAD_BYTES, 1'b1);
      send_item(make_req(dmxrx_pkg::ACT_READ, 8'h00, 1'b0, 9'd509));
      send_item(make_req(dmxrx_pkg::ACT_READ, 8'h00, 1'b0, 9'd510));
      send_item(make_req(dmxrx_pkg::ACT_READ, 8'h00, 1'b0, 9'd511));
      // long poll run: weak link, equal-to-lost hold, lost link
      repeat (int'(dmxrx_pkg::LOST_RESET) + 12) send_item(noise_req(dmxrx_pkg::ACT_POLL));
      send_item(noise_req(dmxrx_pkg::ACT_READ));
      send_item(make_req(dmxrx_pkg::ACT_BYTE, 8'h00, 1'b1, 9'h000));
      run_random(85);

      // Threshold settings: extremes, crossed, small, and fully random
      for (int phase = 1; phase <= 8; phase++) begin
         case (phase)
            1: begin warn = 11'd0;    lost = 11'd0;    end
            2: begin warn = 11'd2047; lost = 11'd2047; end
            3: begin warn = 11'd0;    lost = 11'd2047; end
            4: begin warn = 11'd2047; lost = 11'd0;    end
            5: begin warn = 11'd5;    lost = 11'd12;   end
            6: begin warn = 11'd12;   lost = 11'd5;    end
            7: begin
               warn = 11'($urandom_range(0, 25));
               lost = 11'($urandom_range(0, 25));
            end
            default: begin
               warn = 11'($urandom);
               lost = 11'($urandom);
            end
         endcase
         // some phases run back to back with no sender gaps
         gaps_on = (phase % 3 != 2);
         pause_until_drained();
         write_thresholds(warn, lost);
         run_random(85);
      end

      pause_until_drained();
      repeat (4) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending_outcomes.size() == 0) begin
         $display("dmx_radio_packet_receiver_core regression: pass");
      end else begin
         $display("dmx_radio_packet_receiver_core regression: fail");
      end
      $finish;
   end

endmodule
